FILE: rtl/core/fall_detect_threshold_fsm_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fall detector
// Concurrent checks on clk_i, held off while rst_ni is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef FALL_DETECT_THRESHOLD_FSM_DEFINES_SVH
`define FALL_DETECT_THRESHOLD_FSM_DEFINES_SVH
`ifndef SYNTHESIS
// Check prop at every clock edge outside reset.
`define FDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check an implication: ante at one edge, cons at the next.
`define FDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FDT_ASSERT(lbl, prop, msg)
`define FDT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/fdt_pkg.sv
// ----------------------------------------------------------------------------
// fdt_pkg
// Types, register indexes, widths and helpers for the fall detector.
// ----------------------------------------------------------------------------
`default_nettype none

package fdt_pkg;

  localparam int unsigned AXIS_W   = 16;
  localparam int unsigned SUM_W    = 17;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned WAIT_W   = 16;
  localparam int unsigned ALLOW_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 17;

  localparam int unsigned WINDOW_DEF = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_MS        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_ALLOWANCE = 2'd3;

  // Reset values: 2.5 g at 16384 LSB/g, 70 deg/s at 16.4 LSB/(deg/s)
  localparam logic [SUM_W-1:0]   ACCEL_LIMIT_RST    = 17'd40960;
  localparam logic [SUM_W-1:0]   GYRO_LIMIT_RST     = 17'd1148;
  localparam logic [WAIT_W-1:0]  WAIT_MS_RST        = 16'd2000;
  localparam logic [ALLOW_W-1:0] STEP_ALLOWANCE_RST = 8'd1;

  typedef enum logic {
    ST_WATCH   = 1'b0,
    ST_SUSPECT = 1'b1
  } fdt_state_e;

  // Magnitude of a signed axis; the most negative value maps to 32768.
  function automatic logic [AXIS_W-1:0] abs16(input logic signed [AXIS_W-1:0] v);
    logic [AXIS_W-1:0] neg;
    neg = AXIS_W'(-v);
    return v[AXIS_W-1] ? neg : AXIS_W'(v);
  endfunction

  // Sum of three axis magnitudes, never overflows 17 bits.
  function automatic logic [SUM_W-1:0] sum3(input logic signed [AXIS_W-1:0] a,
                                             input logic signed [AXIS_W-1:0] b,
                                             input logic signed [AXIS_W-1:0] c);
    return SUM_W'(abs16(a)) + SUM_W'(abs16(b)) + SUM_W'(abs16(c));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fall_detect_threshold_fsm.sv
// ----------------------------------------------------------------------------
// fall_detect_threshold_fsm
// Threshold-window fall detector followed by a timed step check.
// ----------------------------------------------------------------------------
// One sample is taken per clock cycle while in_ready_o is high, and each sample
// yields exactly one result beat: the accepting edge loads the gyro and accel
// magnitude sums into the input register; once the result register is free, a
// later edge runs the window compare and the watch/suspect state machine into
// the result register. A held result stalls the input once both registers are
// full. While watching,
// the newest WINDOW sum pairs are kept; when all reach both limits the block goes
// suspect and records the step count and timestamp. Once more than wait_ms has
// elapsed (mod 2^32) the step rise decides: at most step_allowance raises alarm,
// otherwise the block quietly returns to watching. Write the limits only while
// no sample is in flight.
`default_nettype none

`include "fall_detect_threshold_fsm_defines.svh"

module fall_detect_threshold_fsm #(
  parameter int unsigned WINDOW = fdt_pkg::WINDOW_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration writes
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [fdt_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [fdt_pkg::CFG_DAT_W-1:0]        cfg_data_i,
  // sample input
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [fdt_pkg::AXIS_W-1:0]    gyro_x_i,
  input  wire logic signed [fdt_pkg::AXIS_W-1:0]    gyro_y_i,
  input  wire logic signed [fdt_pkg::AXIS_W-1:0]    gyro_z_i,
  input  wire logic signed [fdt_pkg::AXIS_W-1:0]    acc_x_i,
  input  wire logic signed [fdt_pkg::AXIS_W-1:0]    acc_y_i,
  input  wire logic signed [fdt_pkg::AXIS_W-1:0]    acc_z_i,
  input  wire logic [fdt_pkg::CNT_W-1:0]            step_count_i,
  input  wire logic [fdt_pkg::CNT_W-1:0]            now_ms_i,
  // result output
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      alarm_o,
  output logic                                      suspect_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [fdt_pkg::SUM_W-1:0]   accel_limit_q;
  logic [fdt_pkg::SUM_W-1:0]   gyro_limit_q;
  logic [fdt_pkg::WAIT_W-1:0]  wait_ms_q;
  logic [fdt_pkg::ALLOW_W-1:0] step_allow_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_limit_q <= fdt_pkg::ACCEL_LIMIT_RST;
      gyro_limit_q  <= fdt_pkg::GYRO_LIMIT_RST;
      wait_ms_q     <= fdt_pkg::WAIT_MS_RST;
      step_allow_q  <= fdt_pkg::STEP_ALLOWANCE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fdt_pkg::REG_ACCEL_LIMIT:    accel_limit_q <= cfg_data_i;
        fdt_pkg::REG_GYRO_LIMIT:     gyro_limit_q  <= cfg_data_i;
        fdt_pkg::REG_WAIT_MS:        wait_ms_q     <= cfg_data_i[fdt_pkg::WAIT_W-1:0];
        fdt_pkg::REG_STEP_ALLOWANCE: step_allow_q  <= cfg_data_i[fdt_pkg::ALLOW_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register: magnitude sums and the counters
  // --------------------------------------------------------------------------
  logic                        s1_valid_q;
  logic [fdt_pkg::SUM_W-1:0]   gsum_q;
  logic [fdt_pkg::SUM_W-1:0]   asum_q;
  logic [fdt_pkg::CNT_W-1:0]   steps_q;
  logic [fdt_pkg::CNT_W-1:0]   now_q;
  logic                        s1_adv;
  logic                        out_valid_q;
  logic                        alarm_q;
  logic                        suspect_q;

  // Advance when the result slot is empty or its beat leaves this cycle
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      gsum_q  <= fdt_pkg::sum3(gyro_x_i, gyro_y_i, gyro_z_i);
      asum_q  <= fdt_pkg::sum3(acc_x_i, acc_y_i, acc_z_i);
      steps_q <= step_count_i;
      now_q   <= now_ms_i;
    end
  end

  // --------------------------------------------------------------------------
  // Window, decision logic and state
  // --------------------------------------------------------------------------
  logic [fdt_pkg::SUM_W-1:0] gwin_q [WINDOW];
  logic [fdt_pkg::SUM_W-1:0] awin_q [WINDOW];
  logic [fdt_pkg::SUM_W-1:0] gwin_d [WINDOW];
  logic [fdt_pkg::SUM_W-1:0] awin_d [WINDOW];
  logic                      all_hit;
  logic [fdt_pkg::CNT_W-1:0] saved_steps_q;
  logic [fdt_pkg::CNT_W-1:0] saved_time_q;
  logic [fdt_pkg::CNT_W-1:0] elapsed;
  logic [fdt_pkg::CNT_W-1:0] step_rise;
  logic                      timeout;
  logic                      step_ok;

  fdt_pkg::fdt_state_e state_q, state_d;
  logic alarm_d;
  logic win_upd;
  logic save_ctr;

  always_comb begin
    for (int i = WINDOW - 1; i > 0; i--) begin
      gwin_d[i] = gwin_q[i-1];
      awin_d[i] = awin_q[i-1];
    end
    gwin_d[0] = gsum_q;
    awin_d[0] = asum_q;
    all_hit = 1'b1;
    for (int i = 0; i < WINDOW; i++) begin
      if (awin_d[i] < accel_limit_q || gwin_d[i] < gyro_limit_q) begin
        all_hit = 1'b0;
      end
    end
  end

  assign elapsed   = now_q - saved_time_q;
  assign step_rise = steps_q - saved_steps_q;
  assign timeout   = elapsed > fdt_pkg::CNT_W'(wait_ms_q);
  assign step_ok   = step_rise <= fdt_pkg::CNT_W'(step_allow_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fdt_pkg::ST_WATCH: begin
        if (all_hit) begin
          state_d = fdt_pkg::ST_SUSPECT;
        end
      end
      fdt_pkg::ST_SUSPECT: begin
        if (timeout) begin
          state_d = fdt_pkg::ST_WATCH;
        end
      end
      default: state_d = fdt_pkg::ST_WATCH;
    endcase
  end

  // state outputs
  always_comb begin
    alarm_d  = 1'b0;
    win_upd  = 1'b0;
    save_ctr = 1'b0;
    case (state_q)
      fdt_pkg::ST_WATCH: begin
        win_upd  = 1'b1;
        save_ctr = all_hit;
      end
      fdt_pkg::ST_SUSPECT: begin
        alarm_d = timeout && step_ok;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= fdt_pkg::ST_WATCH;
      saved_steps_q <= '0;
      saved_time_q  <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        gwin_q[i] <= '0;
        awin_q[i] <= '0;
      end
    end else if (s1_adv) begin
      state_q <= state_d;
      if (win_upd) begin
        gwin_q <= gwin_d;
        awin_q <= awin_d;
      end
      if (save_ctr) begin
        saved_steps_q <= steps_q;
        saved_time_q  <= now_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      alarm_q   <= alarm_d;
      suspect_q <= (state_d == fdt_pkg::ST_SUSPECT);
    end
  end

  assign out_valid_o = out_valid_q;
  assign alarm_o     = alarm_q;
  assign suspect_o   = suspect_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `FDT_ASSERT(a_alarm_leaves_suspect, !(out_valid_q && alarm_q && suspect_q),
              "alarm beat still flagged suspect")
  `FDT_ASSERT_NEXT(a_no_alarm_from_watch, s1_adv && (state_q == fdt_pkg::ST_WATCH),
                   !alarm_q, "alarm raised from watching state")
  `FDT_ASSERT(a_suspect_tracks_state,
              !out_valid_q || (suspect_q == (state_q == fdt_pkg::ST_SUSPECT)),
              "suspect flag out of step with state")

endmodule

`default_nettype wire

FILE: dv/tb_fall_detect_threshold_fsm.sv
// ----------------------------------------------------------------------------
// tb_fall_detect_threshold_fsm
// Self-checking bench for the fall detector. A scoreboard class keeps its own
// copy of the sum window and of the watch/suspect state. It predicts alarm and
// suspect for every accepted sample and checks each result beat in order.
// Directed samples come first, then mostly well-formed fall sequences with
// random content under several limit settings. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_fall_detect_threshold_fsm;
  timeunit 1ns;
  timeprecision 1ps;

  import fdt_pkg::*;

  localparam int HIST           = WINDOW_DEF;
  localparam int PHASES         = 8;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [SUM_W-1:0] SUM_MAX = 17'd98304;

  typedef struct {
    logic signed [AXIS_W-1:0] gx, gy, gz, ax, ay, az;
    logic [CNT_W-1:0]         steps;
    logic [CNT_W-1:0]         now;
  } sample_t;

  typedef struct {
    logic alarm;
    logic suspect;
  } verdict_t;

  class fall_scoreboard;
    logic [SUM_W-1:0]   accel_lim;
    logic [SUM_W-1:0]   gyro_lim;
    logic [WAIT_W-1:0]  wait_lim;
    logic [ALLOW_W-1:0] allow_lim;
    logic [SUM_W-1:0]   accel_hist [HIST];
    logic [SUM_W-1:0]   gyro_hist [HIST];
    fdt_state_e         state;
    logic [CNT_W-1:0]   saved_steps;
    logic [CNT_W-1:0]   saved_time;
    verdict_t           verdict_q [$];
    int                 errors;

    function new();
      accel_lim   = ACCEL_LIMIT_RST;
      gyro_lim    = GYRO_LIMIT_RST;
      wait_lim    = WAIT_MS_RST;
      allow_lim   = STEP_ALLOWANCE_RST;
      for (int i = 0; i < HIST; i++) begin
        accel_hist[i] = '0;
        gyro_hist[i]  = '0;
      end
      state       = ST_WATCH;
      saved_steps = '0;
      saved_time  = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_ACCEL_LIMIT:    accel_lim = data[SUM_W-1:0];
        REG_GYRO_LIMIT:     gyro_lim  = data[SUM_W-1:0];
        REG_WAIT_MS:        wait_lim  = data[WAIT_W-1:0];
        REG_STEP_ALLOWANCE: allow_lim = data[ALLOW_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [SUM_W-1:0] mag(logic signed [AXIS_W-1:0] v);
      int iv;
      iv = v;
      return SUM_W'((iv < 0) ? -iv : iv);
    endfunction

    function void note_sample(sample_t s);
      verdict_t v;
      bit       all_hit;
      v.alarm = 1'b0;
      if (state == ST_WATCH) begin
        for (int i = HIST - 1; i > 0; i--) begin
          accel_hist[i] = accel_hist[i-1];
          gyro_hist[i]  = gyro_hist[i-1];
        end
        gyro_hist[0]  = mag(s.gx) + mag(s.gy) + mag(s.gz);
        accel_hist[0] = mag(s.ax) + mag(s.ay) + mag(s.az);
        all_hit = 1'b1;
        for (int i = 0; i < HIST; i++) begin
          if (accel_hist[i] < accel_lim || gyro_hist[i] < gyro_lim) all_hit = 1'b0;
        end
        if (all_hit) begin
          state       = ST_SUSPECT;
          saved_steps = s.steps;
          saved_time  = s.now;
        end
      end else if (CNT_W'(s.now - saved_time) > CNT_W'(wait_lim)) begin
        // elapsed and rise both wrap modulo 2^32
        if (CNT_W'(s.steps - saved_steps) <= CNT_W'(allow_lim)) v.alarm = 1'b1;
        state = ST_WATCH;
      end
      v.suspect = (state == ST_SUSPECT);
      verdict_q.push_back(v);
    endfunction

    function void check_result(logic alarm, logic suspect);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: alarm %b suspect %b",
                 $time, alarm, suspect);
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (alarm !== v.alarm) begin
        $display("%0t: alarm mismatch: expected %b actual %b", $time, v.alarm, alarm);
        errors++;
      end
      if (suspect !== v.suspect) begin
        $display("%0t: suspect mismatch: expected %b actual %b", $time, v.suspect, suspect);
        errors++;
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function void report_leftover();
      if (verdict_q.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time, verdict_q.size());
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [CFG_DAT_W-1:0]     cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [AXIS_W-1:0] gyro_x_i, gyro_y_i, gyro_z_i;
  logic signed [AXIS_W-1:0] acc_x_i, acc_y_i, acc_z_i;
  logic [CNT_W-1:0]         step_count_i;
  logic [CNT_W-1:0]         now_ms_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     alarm_o;
  logic                     suspect_o;

  fall_scoreboard   sb;
  logic [CNT_W-1:0] cur_time;
  logic [CNT_W-1:0] cur_steps;
  int               tx_run;
  int               rx_run;
  bit               hold_req;

  fall_detect_threshold_fsm dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly back-to-back, some short gaps, a few long ones, and zero-gap runs.
  function automatic int pick_gap(inout int run_left);
    int r;
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      run_left = $urandom_range(10, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [AXIS_W-1:0] axis_of(int m);
    if (m >= 32768) return 16'sh8000;
    return ($urandom_range(0, 1) != 0) ? AXIS_W'(-m) : AXIS_W'(m);
  endfunction

  // Axis magnitude such that three of them reach the limit, or stay below it.
  function automatic int mag_for(logic [SUM_W-1:0] lim, bit reach);
    if (reach) return $urandom_range((int'(lim) + 2) / 3, 32768);
    if (lim == '0) return $urandom_range(0, 32768);
    return $urandom_range(0, (int'(lim) - 1) / 3);
  endfunction

  function automatic sample_t sample_of(int gx, int gy, int gz, int ax, int ay, int az,
                                        logic [CNT_W-1:0] steps, logic [CNT_W-1:0] now);
    sample_t s;
    s.gx = AXIS_W'(gx);
    s.gy = AXIS_W'(gy);
    s.gz = AXIS_W'(gz);
    s.ax = AXIS_W'(ax);
    s.ay = AXIS_W'(ay);
    s.az = AXIS_W'(az);
    s.steps = steps;
    s.now = now;
    return s;
  endfunction

  function automatic sample_t shaped_sample(bit gyro_hit, bit accel_hit);
    sample_t s;
    s.gx = axis_of(mag_for(sb.gyro_lim, gyro_hit));
    s.gy = axis_of(mag_for(sb.gyro_lim, gyro_hit));
    s.gz = axis_of(mag_for(sb.gyro_lim, gyro_hit));
    s.ax = axis_of(mag_for(sb.accel_lim, accel_hit));
    s.ay = axis_of(mag_for(sb.accel_lim, accel_hit));
    s.az = axis_of(mag_for(sb.accel_lim, accel_hit));
    s.steps = cur_steps + $urandom_range(0, 2);
    s.now = cur_time + $urandom_range(0, 40);
    return s;
  endfunction

  function automatic sample_t noise_sample();
    sample_t s;
    s.gx = AXIS_W'($urandom);
    s.gy = AXIS_W'($urandom);
    s.gz = AXIS_W'($urandom);
    s.ax = AXIS_W'($urandom);
    s.ay = AXIS_W'($urandom);
    s.az = AXIS_W'($urandom);
    if ($urandom_range(0, 1) != 0) begin
      s.steps = $urandom;
      s.now = $urandom;
    end else begin
      s.steps = cur_steps + $urandom_range(0, 3);
      s.now = cur_time + $urandom_range(0, 100);
    end
    return s;
  endfunction

  // While suspect the axes are ignored; time and steps are set around the
  // wait and allowance boundaries relative to the recorded values.
  function automatic sample_t suspect_sample();
    sample_t          s;
    logic [CNT_W-1:0] waited;
    logic [CNT_W-1:0] rise;
    int               r;
    s = noise_sample();
    r = $urandom_range(0, 99);
    if (r < 35) waited = $urandom_range(0, sb.wait_lim);
    else if (r < 45) waited = sb.wait_lim;
    else if (r < 55) waited = sb.wait_lim + 1;
    else if (r < 90) waited = sb.wait_lim + $urandom_range(1, 5000);
    else waited = $urandom;
    r = $urandom_range(0, 99);
    if (r < 40) rise = $urandom_range(0, sb.allow_lim);
    else if (r < 55) rise = sb.allow_lim;
    else if (r < 70) rise = sb.allow_lim + 1;
    else if (r < 85) rise = $urandom_range(sb.allow_lim + 1, 5000);
    else rise = -$urandom_range(1, 100);
    s.now = sb.saved_time + waited;
    s.steps = sb.saved_steps + rise;
    return s;
  endfunction

  task automatic send_sample(sample_t s);
    int gap;
    gap = pick_gap(tx_run);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    gyro_x_i     <= s.gx;
    gyro_y_i     <= s.gy;
    gyro_z_i     <= s.gz;
    acc_x_i      <= s.ax;
    acc_y_i      <= s.ay;
    acc_z_i      <= s.az;
    step_count_i <= s.steps;
    now_ms_i     <= s.now;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s);
    cur_time  = s.now;
    cur_steps = s.steps;
  endtask

  // Hold the input side until every expected beat is back, then let the
  // pipeline settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(logic [SUM_W-1:0] acc_lim, logic [SUM_W-1:0] gyr_lim,
                                logic [WAIT_W-1:0] wait_val, logic [ALLOW_W-1:0] allow_val);
    write_reg(REG_ACCEL_LIMIT, acc_lim);
    write_reg(REG_GYRO_LIMIT, gyr_lim);
    write_reg(REG_WAIT_MS, CFG_DAT_W'(wait_val));
    write_reg(REG_STEP_ALLOWANCE, CFG_DAT_W'(allow_val));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    // zero limits: the cleared window already passes on the first sample
    write_reg(REG_ACCEL_LIMIT, '0);
    write_reg(REG_GYRO_LIMIT, '0);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    send_sample(sample_of(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FC00));
    // exactly wait_ms across the time wrap: no decision yet
    send_sample(sample_of(0, 0, 0, 0, 0, 0, 32'h0, 32'h0000_03D0));
    // one ms more, step count wrapped by one: alarm
    send_sample(sample_of(0, 0, 0, 0, 0, 0, 32'h0, 32'h0000_03D1));
    drain();
    write_reg(REG_ACCEL_LIMIT, ACCEL_LIMIT_RST);
    write_reg(REG_GYRO_LIMIT, GYRO_LIMIT_RST);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    send_sample(sample_of(-32768, -32768, -32768, -32768, -32768, -32768, 10, 5000));
    send_sample(sample_of(32767, 32767, 32767, 32767, 32767, 32767, 10, 5010));
    send_sample(sample_of(-32768, 32767, -32768, 32767, -32768, 32767, 10, 6000));
    // rise of two is too many steps: back to watching
    send_sample(sample_of(1, 2, 3, 4, 5, 6, 12, 8001));
    send_sample(sample_of(400, -400, 400, 20480, -20480, 20480, 50, 9000));
    // count going backwards looks like a huge rise
    send_sample(sample_of(0, 0, 0, 0, 0, 0, 49, 11001));
    send_sample(sample_of(32767, 32767, 32767, 0, 0, 0, 60, 12000));
    send_sample(sample_of(383, -383, 382, 13654, -13653, 13653, 61, 12100));
    send_sample(sample_of(-1, -1, -1, -1, -1, -1, 62, 12200));
    send_sample(sample_of(383, 383, -382, -13654, 13653, 13653, 100, 19000));
    send_sample(sample_of(-383, 383, 382, 13654, 13653, -13653, 100, 19500));
    // both limits met with no margin
    send_sample(sample_of(383, 383, 382, 13654, 13653, 13653, 100, 20000));
    send_sample(sample_of(0, 0, 0, 0, 0, 0, 101, 22001));
    send_sample(sample_of(383, 383, 382, 13653, 13653, 13653, 101, 22100));
    send_sample(sample_of(-32768, -32768, -32768, -32768, -32768, -32768,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
    drain();
  endtask

  task automatic run_random(int count);
    int      plan;
    int      r;
    sample_t s;
    plan = 0;
    for (int k = 0; k < count; k++) begin
      if (sb.state == ST_WATCH && plan == 0 && $urandom_range(0, 99) < 70)
        plan = HIST + $urandom_range(0, 1);
      if (sb.state == ST_SUSPECT) begin
        s = suspect_sample();
      end else if (plan > 0) begin
        plan--;
        // now and then one side misses and breaks the sequence
        r = $urandom_range(0, 99);
        s = shaped_sample(r >= 6, !(r >= 6 && r < 12));
      end else if ($urandom_range(0, 1) != 0) begin
        s = shaped_sample(1'b0, 1'b0);
      end else begin
        s = noise_sample();
      end
      send_sample(s);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(alarm_o, suspect_o);
  end

  // Receiver: random ready pattern, plus one long hold-off on request.
  initial begin
    int g;
    out_ready_i = 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        g = LONG_HOLD;
      end else begin
        g = pick_gap(rx_run);
      end
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    sb           = new();
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    gyro_x_i     = '0;
    gyro_y_i     = '0;
    gyro_z_i     = '0;
    acc_x_i      = '0;
    acc_y_i      = '0;
    acc_z_i      = '0;
    step_count_i = '0;
    now_ms_i     = '0;
    cur_time     = '0;
    cur_steps    = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: apply_settings(ACCEL_LIMIT_RST, GYRO_LIMIT_RST, WAIT_MS_RST, STEP_ALLOWANCE_RST);
        1: apply_settings('0, '0, '0, '0);
        2: apply_settings(SUM_MAX, SUM_MAX, '1, '1);
        default: apply_settings(SUM_W'($urandom_range(0, 98304)),
                                SUM_W'($urandom_range(0, 98304)),
                                WAIT_W'($urandom_range(0, 3000)),
                                ALLOW_W'($urandom_range(0, 255)));
      endcase
      // stall the output side long enough to back up the input
      if (p == 4) hold_req = 1'b1;
      run_random(RANDOM_ITEMS / PHASES);
    end
    drain();
    sb.report_leftover();
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
